// File: rtl/core/segment_polygon_collision_unit_macros.svh
// Assertion macros for the segment polygon collision unit
`ifndef SEGMENT_POLYGON_COLLISION_UNIT_MACROS_SVH
`define SEGMENT_POLYGON_COLLISION_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SPC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SPC_ASSERT(label, clk, rst_n, prop)
`define SPC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/core/spc_pkg.sv
`default_nettype none
package spc_pkg;
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_FEW   = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] bx;
        logic signed [15:0] by;
    } in_word_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
        logic [4:0] vertex_count;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch query endpoints
        logic rd;       // issue store read of current side
        logic side_go;  // products valid, evaluate side
        logic clr_flags;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic a_out;     // endpoint a seen on both sides
        logic b_out;
        logic side_met;  // some side met
    } dp_stat_t;
endpackage
`default_nettype wire

// File: rtl/core/spc_if.sv
`default_nettype none
interface spc_in_if;
    logic               valid;
    logic               ready;
    spc_pkg::in_word_t  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface spc_out_if;
    logic               valid;
    logic               ready;
    spc_pkg::out_word_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/spc_datapath.sv
`default_nettype none
module spc_datapath #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 16,
    parameter int IDX_BITS     = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [IDX_BITS-1:0]  wr_idx,
    input  wire logic [IDX_BITS-1:0]  rd_i,
    input  wire logic [IDX_BITS-1:0]  rd_j,
    input  wire spc_pkg::in_word_t    word,
    input  wire spc_pkg::dp_cmd_t     cmd,
    output spc_pkg::dp_stat_t         stat
);
    import spc_pkg::*;
    localparam int W = COORD_BITS + 1;
    localparam int P = 2 * W;
    localparam int S = P + 1;

    logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, dx_reg, dy_reg;
    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_idx] <= word.ax[COORD_BITS-1:0];
            mem_y[wr_idx] <= word.ay[COORD_BITS-1:0];
        end
        if (cmd.rd)
        begin
            cx_reg <= mem_x[rd_i];
            cy_reg <= mem_y[rd_i];
            dx_reg <= mem_x[rd_j];
            dy_reg <= mem_y[rd_j];
        end
        if (cmd.load)
        begin
            ax_reg <= word.ax[COORD_BITS-1:0];
            ay_reg <= word.ay[COORD_BITS-1:0];
            bx_reg <= word.bx[COORD_BITS-1:0];
            by_reg <= word.by[COORD_BITS-1:0];
        end
    end

    // differences, one register stage of products
    logic signed [W-1:0] ex, ey, sx, sy, acx, acy, bcx, bcy, adx, ady, bdx, bdy;
    always_comb
    begin
        ex  = W'(dx_reg) - W'(cx_reg);
        ey  = W'(dy_reg) - W'(cy_reg);
        sx  = W'(bx_reg) - W'(ax_reg);
        sy  = W'(by_reg) - W'(ay_reg);
        acx = W'(ax_reg) - W'(cx_reg);
        acy = W'(ay_reg) - W'(cy_reg);
        bcx = W'(bx_reg) - W'(cx_reg);
        bcy = W'(by_reg) - W'(cy_reg);
        adx = W'(ax_reg) - W'(dx_reg);
        ady = W'(ay_reg) - W'(dy_reg);
        bdx = W'(bx_reg) - W'(dx_reg);
        bdy = W'(by_reg) - W'(dy_reg);
    end

    logic signed [P-1:0] p_ca1_reg, p_ca2_reg, p_cb1_reg, p_cb2_reg;
    logic signed [P-1:0] p_ac1_reg, p_ac2_reg, p_ad1_reg, p_ad2_reg;
    logic signed [P-1:0] p_d1_reg, p_d2_reg, p_u1_reg, p_u2_reg;
    logic signed [COORD_BITS-1:0] e_ax_reg, e_ay_reg, e_bx_reg, e_by_reg;
    logic signed [COORD_BITS-1:0] e_cx_reg, e_cy_reg, e_dx_reg, e_dy_reg;

    always_ff @(posedge clk)
    begin
        p_ca1_reg <= P'(acx) * P'(ey);   // cross of A against side
        p_ca2_reg <= P'(acy) * P'(ex);
        p_cb1_reg <= P'(bcx) * P'(ey);
        p_cb2_reg <= P'(bcy) * P'(ex);
        p_ac1_reg <= P'(acx) * P'(sy);   // cross of C against segment: (c-a) x s
        p_ac2_reg <= P'(acy) * P'(sx);
        p_ad1_reg <= P'(adx) * P'(sy);
        p_ad2_reg <= P'(ady) * P'(sx);
        p_d1_reg  <= P'(ex) * P'(sy);    // det = ex*(ay-by) - (ax-bx)*ey = -(ex*sy - sx*ey)
        p_d2_reg  <= P'(sx) * P'(ey);
        p_u1_reg  <= P'(sy) * P'(acx);   // un = -sy*acx + sx*acy
        p_u2_reg  <= P'(sx) * P'(acy);
        e_ax_reg <= ax_reg; e_ay_reg <= ay_reg; e_bx_reg <= bx_reg; e_by_reg <= by_reg;
        e_cx_reg <= cx_reg; e_cy_reg <= cy_reg; e_dx_reg <= dx_reg; e_dy_reg <= dy_reg;
    end

    logic signed [S-1:0] cra, crb, crc, crd, det, tn, un;
    logic det_neg;
    logic signed [S-1:0] detp, tnp, unp;
    logic on_c, on_d, on_a, on_b, meet;

    function automatic logic inbox(input logic signed [COORD_BITS-1:0] p,
                                   input logic signed [COORD_BITS-1:0] u,
                                   input logic signed [COORD_BITS-1:0] v);
        inbox = (u <= v) ? (p >= u && p <= v) : (p >= v && p <= u);
    endfunction

    always_comb
    begin
        cra = S'(p_ca1_reg) - S'(p_ca2_reg);
        crb = S'(p_cb1_reg) - S'(p_cb2_reg);
        crc = S'(p_ac2_reg) - S'(p_ac1_reg);
        crd = S'(p_ad2_reg) - S'(p_ad1_reg);
        det = S'(p_d2_reg) - S'(p_d1_reg);
        // tn = (cy-dy)(ax-cx)+(dx-cx)(ay-cy) = ex*acy - ey*acx = -cra
        tn  = -cra;
        un  = S'(p_u2_reg) - S'(p_u1_reg);
        det_neg = det[S-1];
        detp = det_neg ? -det : det;
        tnp  = det_neg ? -tn : tn;
        unp  = det_neg ? -un : un;
        on_c = (crc == '0) && inbox(e_cx_reg, e_ax_reg, e_bx_reg) &&
               inbox(e_cy_reg, e_ay_reg, e_by_reg);
        on_d = (crd == '0) && inbox(e_dx_reg, e_ax_reg, e_bx_reg) &&
               inbox(e_dy_reg, e_ay_reg, e_by_reg);
        on_a = (cra == '0) && inbox(e_ax_reg, e_cx_reg, e_dx_reg) &&
               inbox(e_ay_reg, e_cy_reg, e_dy_reg);
        on_b = (crb == '0) && inbox(e_bx_reg, e_cx_reg, e_dx_reg) &&
               inbox(e_by_reg, e_cy_reg, e_dy_reg);
        if (det == '0)
            meet = on_c || on_d || on_a || on_b;
        else
            meet = !tnp[S-1] && tnp <= detp && !unp[S-1] && unp <= detp;
    end

    logic a_pos_reg, a_neg_reg, b_pos_reg, b_neg_reg, met_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_pos_reg <= 1'b0; a_neg_reg <= 1'b0;
            b_pos_reg <= 1'b0; b_neg_reg <= 1'b0;
            met_reg   <= 1'b0;
        end
        else if (cmd.clr_flags)
        begin
            a_pos_reg <= 1'b0; a_neg_reg <= 1'b0;
            b_pos_reg <= 1'b0; b_neg_reg <= 1'b0;
            met_reg   <= 1'b0;
        end
        else if (cmd.side_go)
        begin
            // d = (p-c) x (d-c) sign; cra has that sign
            if (cra > 0) a_pos_reg <= 1'b1;
            if (cra < 0) a_neg_reg <= 1'b1;
            if (crb > 0) b_pos_reg <= 1'b1;
            if (crb < 0) b_neg_reg <= 1'b1;
            if (meet) met_reg <= 1'b1;
        end
    end

    assign stat.a_out    = a_pos_reg && a_neg_reg;
    assign stat.b_out    = b_pos_reg && b_neg_reg;
    assign stat.side_met = met_reg;
endmodule
`default_nettype wire

// File: rtl/core/spc_control.sv
`default_nettype none
`include "segment_polygon_collision_unit_macros.svh"
module spc_control #(
    parameter int MAX_VERTICES = 16,
    parameter int IDX_BITS     = 4,
    parameter int CNT_BITS     = 5
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          opcode,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output spc_pkg::out_word_t       out_word,
    output logic                     wr_en,
    output logic [IDX_BITS-1:0]      wr_idx,
    output logic [IDX_BITS-1:0]      rd_i,
    output logic [IDX_BITS-1:0]      rd_j,
    output spc_pkg::dp_cmd_t         cmd,
    input  wire spc_pkg::dp_stat_t   stat
);
    import spc_pkg::*;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [CNT_BITS-1:0] iss_reg, iss_next;     // sides issued
    logic [CNT_BITS-1:0] done_reg, done_next;   // sides evaluated
    logic                rdv_reg, pv_reg;       // read and product stage valid
    logic                ov_reg, ov_next;
    out_word_t           ow_reg, ow_next;

    logic accept;
    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_word  = ow_reg;
    assign wr_idx    = count_reg[IDX_BITS-1:0];
    assign wr_en     = accept && opcode == OP_APPEND &&
                       count_reg < CNT_BITS'(MAX_VERTICES);
    assign rd_i      = iss_reg[IDX_BITS-1:0];
    assign rd_j      = (iss_reg + 1'b1 == count_reg) ? '0 : IDX_BITS'(iss_reg + 1'b1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        iss_next   = iss_reg;
        done_next  = done_reg;
        ov_next    = ov_reg;
        ow_next    = ow_reg;
        cmd        = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ow_next = '{hit: 1'b0, status: ST_OK, vertex_count: count_reg};
                    case (opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ow_next.vertex_count = '0;
                            ov_next = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg < CNT_BITS'(MAX_VERTICES))
                            begin
                                count_next = count_reg + 1'b1;
                                ow_next.vertex_count = count_reg + 1'b1;
                            end
                            else
                                ow_next.status = ST_FULL;
                            ov_next = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            if (count_reg < CNT_BITS'(3))
                            begin
                                ow_next.status = ST_FEW;
                                ov_next = 1'b1;
                            end
                            else
                            begin
                                cmd.load = 1'b1;
                                cmd.clr_flags = 1'b1;
                                iss_next = '0;
                                done_next = '0;
                                state_next = S_RUN;
                            end
                        end
                        default:
                            ov_next = 1'b1;
                    endcase
                end
            end
            S_RUN:
            begin
                if (iss_reg < count_reg)
                begin
                    cmd.rd = 1'b1;
                    iss_next = iss_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    cmd.side_go = 1'b1;
                    done_next = done_reg + 1'b1;
                end
                if (done_reg == count_reg)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                ow_next.hit = !stat.a_out || !stat.b_out || stat.side_met;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            iss_reg   <= '0;
            done_reg  <= '0;
            rdv_reg   <= 1'b0;
            pv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            iss_reg   <= iss_next;
            done_reg  <= done_next;
            rdv_reg   <= cmd.rd;
            pv_reg    <= rdv_reg;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ow_reg <= ow_next;
    end

    `SPC_ASSERT(a_cnt_max, clk, rst_n, count_reg <= CNT_BITS'(MAX_VERTICES))
    `SPC_ASSERT(a_no_acc_busy, clk, rst_n, state_reg != S_IDLE |-> !in_ready)
    `SPC_ASSERT(a_done_le_iss, clk, rst_n, done_reg <= iss_reg)
    `SPC_ASSERT(a_out_hold, clk, rst_n,
        out_valid && !out_ready |=> out_valid && $stable(out_word))
endmodule
`default_nettype wire

// File: rtl/core/segment_polygon_collision_unit.sv
`default_nettype none
// channel | dir | fields
// in_ch   | in  | opcode ax ay bx by
// out_ch  | out | hit status vertex_count
// Clear, append and short queries answer in the cycle after the word is taken.
// A query with N sides issues one store read of a side per
// cycle, then a product stage and a side evaluation stage.
// Reset clears the vertex count and all control; the store is not cleared.
// No new word is taken while a result waits on out_ch.
module segment_polygon_collision_unit #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    spc_in_if.sink    in_ch,
    spc_out_if.source out_ch
);
    import spc_pkg::*;
    localparam int IDX_BITS = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);

    logic                wr_en;
    logic [IDX_BITS-1:0] wr_idx, rd_i, rd_j;
    dp_cmd_t             cmd;
    dp_stat_t            stat;
    out_word_t           ow;

    spc_control #(.MAX_VERTICES(MAX_VERTICES), .IDX_BITS(IDX_BITS),
                  .CNT_BITS(CNT_BITS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .opcode(in_ch.data.opcode),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_word(ow),
        .wr_en(wr_en), .wr_idx(wr_idx), .rd_i(rd_i), .rd_j(rd_j),
        .cmd(cmd), .stat(stat)
    );

    spc_datapath #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS),
                   .IDX_BITS(IDX_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_idx(wr_idx),
        .rd_i(rd_i), .rd_j(rd_j), .word(in_ch.data), .cmd(cmd), .stat(stat)
    );

    assign out_ch.data = ow;
endmodule
`default_nettype wire
